>>> design/wsfh_pkg.sv
// Package for the word shingle FNV hasher: widths, reset values, register indexes
// and the control structure that drives the accumulator cells.
// It has no dependencies; every other design file refers to it by scoped names.
package wsfh_pkg;

	localparam int HASH_W = 64;
	localparam int HALF_W = HASH_W / 2;
	localparam int BYTE_W = 8;
	localparam int WINDOW_WORDS = 5;
	localparam int WSEEN_W = $clog2(WINDOW_WORDS + 1);
	localparam int CNT_W = $clog2(HASH_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [HASH_W-1:0] OFFSET_RESET = 64'd14695981039346656037;
	localparam logic [HASH_W-1:0] PRIME_RESET = 64'd1099511628211;
	localparam logic [HASH_W-1:0] MODULUS_RESET = 64'd4294967296;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BASIS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_PRIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODULUS = 2'd2;

	typedef struct packed {
		logic mul1;
		logic mul2;
		logic restart;
		logic shift;
	} cell_ctrl_t;

endpackage

>>> design/wsfh_cell.sv
// One accumulator cell of the window chain: a 64-bit FNV-1 step split over mul1 and mul2.
// The cell passes its accumulator to its lower neighbor when the oldest window retires.
// Depends on wsfh_pkg.
module wsfh_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wsfh_pkg::cell_ctrl_t         ctrl,
	input  logic                         en,
	input  logic [wsfh_pkg::HASH_W-1:0]  prime,
	input  logic [wsfh_pkg::HASH_W-1:0]  xor_val,
	input  logic [wsfh_pkg::HASH_W-1:0]  offset,
	input  logic [wsfh_pkg::HASH_W-1:0]  next_acc,
	output logic [wsfh_pkg::HASH_W-1:0]  acc
);

	localparam int HW = wsfh_pkg::HASH_W;
	localparam int HF = wsfh_pkg::HALF_W;

	logic [HW-1:0] acc_q;
	logic [HW-1:0] lo_q;
	logic [HF-1:0] cross_a_q;
	logic [HW-1:0] mul_lo;
	logic [HF-1:0] mul_a;
	logic [HF-1:0] mul_b;
	logic [HF-1:0] cross_sum;
	logic [HW-1:0] product;

	assign mul_lo = HW'(acc_q[HF-1:0]) * HW'(prime[HF-1:0]);
	assign mul_a = acc_q[HW-1:HF] * prime[HF-1:0];
	assign mul_b = acc_q[HF-1:0] * prime[HW-1:HF];
	assign cross_sum = cross_a_q + mul_b;
	assign product = lo_q + {cross_sum, {HF{1'b0}}};
	assign acc = acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul1) begin
			lo_q <= mul_lo;
			cross_a_q <= mul_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= wsfh_pkg::OFFSET_RESET;
		end else if (ctrl.restart) begin
			acc_q <= offset;
		end else if (ctrl.shift) begin
			acc_q <= next_acc;
		end else if (ctrl.mul2 && en) begin
			acc_q <= product ^ xor_val;
		end
	end

endmodule

>>> design/wsfh_rem.sv
// Serial remainder unit: reduces one window hash by the modulus, one bit per cycle, or
// passes it through when the modulus is zero, and holds the result in the output
// register until the receiver takes it. Depends on wsfh_pkg.
module wsfh_rem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wsfh_pkg::HASH_W-1:0]  hash,
	input  logic                         final_in,
	input  logic [wsfh_pkg::HASH_W-1:0]  modulus,
	output logic                         ready,
	output logic                         valid,
	input  logic                         stall,
	output logic [wsfh_pkg::HASH_W-1:0]  result,
	output logic                         final_out
);

	localparam int HW = wsfh_pkg::HASH_W;
	localparam int CW = wsfh_pkg::CNT_W;

	typedef enum logic [1:0] {R_IDLE, R_RUN, R_DONE} rem_state_t;

	rem_state_t    state_q;
	logic [HW:0]   rem_q;
	logic [HW-1:0] num_q;
	logic [CW-1:0] cnt_q;
	logic          final_q;
	logic          out_valid_q;
	logic [HW-1:0] out_hash_q;
	logic          out_final_q;
	logic          out_free;
	logic [HW:0]   trial;
	logic [HW:0]   diff;

	assign trial = {rem_q[HW-1:0], num_q[HW-1]};
	assign diff = trial - {1'b0, modulus};
	assign out_free = !out_valid_q || !stall;
	assign ready = (state_q == R_IDLE);
	assign valid = out_valid_q;
	assign result = out_hash_q;
	assign final_out = out_final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			rem_q <= '0;
			num_q <= '0;
			cnt_q <= '0;
			final_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_hash_q <= '0;
			out_final_q <= 1'b0;
		end else begin
			if (state_q == R_DONE && out_free) begin
				out_valid_q <= 1'b1;
				out_hash_q <= rem_q[HW-1:0];
				out_final_q <= final_q;
			end else if (!stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				R_IDLE: begin
					if (start) begin
						final_q <= final_in;
						cnt_q <= '0;
						if (modulus == '0) begin
							rem_q <= {1'b0, hash};
							state_q <= R_DONE;
						end else begin
							rem_q <= '0;
							num_q <= hash;
							state_q <= R_RUN;
						end
					end
				end
				R_RUN: begin
					rem_q <= (trial >= {1'b0, modulus}) ? diff : trial;
					num_q <= {num_q[HW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == {CW{1'b1}}) begin
						state_q <= R_DONE;
					end
				end
				R_DONE: begin
					if (out_free) begin
						state_q <= R_IDLE;
					end
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/word_shingle_fnv_hasher_unit.sv
// Top level of the word shingle FNV hasher: configuration registers, sequencing,
// the chain of accumulator cells and the serial remainder unit.
// Depends on wsfh_pkg, wsfh_cell and wsfh_rem.
//
// The input channel takes one text byte per transaction with word-end and
// document-end marks; the output channel delivers one reduced window hash per
// completed window, or one per short document, with final_shingle set on the
// last hash of a document. Configuration writes on the cfg channel are always
// ready; the user must make them while the block is idle, which it does not enforce.
// The 64-bit multiply of every active cell is split into partial products (mul1 at
// the transaction, mul2 in S_MUL2), so in_stall is high in the cycle after each
// transaction. A byte that emits a hash then passes through S_EMIT, which hands the
// oldest window to the remainder unit and shifts the chain, or restarts it at the end
// of a document. The remainder unit works one bit per cycle and then moves the hash
// into its output register, skipping the bit steps when the modulus is zero; a later
// byte that emits a hash waits in S_EMIT until the unit is free.
// The output register holds its transaction while out_stall is high, and input
// bytes keep flowing meanwhile; a hash that finishes while the output register is
// full waits in the remainder unit.
// Reset clears the sequencing, sets all accumulators to the reset offset basis
// and returns the registers to their reset values.
module word_shingle_fnv_hasher_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [wsfh_pkg::BYTE_W-1:0]     text_byte,
	input  logic                            word_last,
	input  logic                            doc_last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [wsfh_pkg::HASH_W-1:0]     shingle_hash,
	output logic                            final_shingle,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wsfh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsfh_pkg::HASH_W-1:0]     cfg_data
);

	localparam int HW = wsfh_pkg::HASH_W;
	localparam int BW = wsfh_pkg::BYTE_W;
	localparam int WW = wsfh_pkg::WINDOW_WORDS;
	localparam int SW = wsfh_pkg::WSEEN_W;

	typedef enum logic [1:0] {S_IDLE, S_MUL2, S_EMIT} state_t;

	state_t               state_q;
	logic [BW-1:0]        byte_q;
	logic                 word_end_q;
	logic                 doc_end_q;
	logic [SW-1:0]        words_seen_q;
	logic [HW-1:0]        offset_basis_q;
	logic [HW-1:0]        hash_prime_q;
	logic [HW-1:0]        hash_modulus_q;

	logic                 accept;
	logic [SW:0]          ws_next;
	logic                 full;
	logic                 emit_need;
	logic                 rem_ready;
	logic                 rem_start;
	logic [HW-1:0]        xor_val;
	wsfh_pkg::cell_ctrl_t ctrl;
	logic [HW-1:0]        acc [WW];
	logic [WW-1:0]        en;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign ws_next = {1'b0, words_seen_q} + 1'b1;
	assign full = (ws_next >= (SW + 1)'(WW));
	assign emit_need = word_end_q && (full || doc_end_q);
	assign rem_start = (state_q == S_EMIT) && rem_ready;
	assign xor_val = {{(HW - BW){byte_q[BW-1]}}, byte_q};

	always_comb begin
		ctrl.mul1 = accept;
		ctrl.mul2 = (state_q == S_MUL2);
		ctrl.restart = rem_start && doc_end_q;
		ctrl.shift = rem_start && !doc_end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_basis_q <= wsfh_pkg::OFFSET_RESET;
			hash_prime_q <= wsfh_pkg::PRIME_RESET;
			hash_modulus_q <= wsfh_pkg::MODULUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wsfh_pkg::CFG_OFFSET_BASIS: offset_basis_q <= cfg_data;
				wsfh_pkg::CFG_HASH_PRIME: hash_prime_q <= cfg_data;
				wsfh_pkg::CFG_HASH_MODULUS: hash_modulus_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			byte_q <= '0;
			word_end_q <= 1'b0;
			doc_end_q <= 1'b0;
			words_seen_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						byte_q <= text_byte;
						word_end_q <= word_last || doc_last;
						doc_end_q <= doc_last;
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (emit_need) begin
						state_q <= S_EMIT;
					end else begin
						if (word_end_q) begin
							words_seen_q <= ws_next[SW-1:0];
						end
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (rem_ready) begin
						words_seen_q <= doc_end_q ? '0 : SW'(WW);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	for (genvar k = 0; k < WW; k++) begin : g_cell
		logic [HW-1:0] next_acc;

		assign en[k] = full || (SW'(k) <= words_seen_q);

		if (k == WW - 1) begin : g_tail
			assign next_acc = offset_basis_q;
		end else begin : g_body
			assign next_acc = acc[k + 1];
		end

		wsfh_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.en       (en[k]),
			.prime    (hash_prime_q),
			.xor_val  (xor_val),
			.offset   (offset_basis_q),
			.next_acc (next_acc),
			.acc      (acc[k])
		);
	end

	wsfh_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.hash      (acc[0]),
		.final_in  (doc_end_q),
		.modulus   (hash_modulus_q),
		.ready     (rem_ready),
		.valid     (out_valid),
		.stall     (out_stall),
		.result    (shingle_hash),
		.final_out (final_shingle)
	);

	// The count of completed words never passes the window length.
	a_words_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		words_seen_q <= SW'(WW))
		else $error("words_seen exceeds the window length");

	// An accepted transaction always moves on to the second multiply cycle.
	a_accept_mul2: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MUL2))
		else $error("accepted byte did not enter the second multiply cycle");

	// A hand-off to the remainder unit leaves it busy in the next cycle.
	a_rem_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |=> !rem_ready)
		else $error("remainder unit not busy after a hand-off");

	// Restart and shift of the cell chain never happen together.
	a_ctrl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.restart && ctrl.shift))
		else $error("cell chain restarted and shifted at once");

endmodule

>>> bench/tb.sv
// Testbench for word_shingle_fnv_hasher_unit: a queue-fed byte driver, a stalling result
// monitor and an in-bench shingle hash predictor that is checked transaction by transaction.
// Depends on wsfh_pkg and the design files of the block.
module tb;
	localparam int BYTE_W = wsfh_pkg::BYTE_W;
	localparam int HASH_W = wsfh_pkg::HASH_W;
	localparam int CFG_IDX_W = wsfh_pkg::CFG_IDX_W;
	localparam int WINDOW_WORDS = wsfh_pkg::WINDOW_WORDS;
	localparam logic [HASH_W-1:0] OFFSET_RESET = wsfh_pkg::OFFSET_RESET;
	localparam logic [HASH_W-1:0] PRIME_RESET = wsfh_pkg::PRIME_RESET;
	localparam logic [HASH_W-1:0] MODULUS_RESET = wsfh_pkg::MODULUS_RESET;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BASIS = wsfh_pkg::CFG_OFFSET_BASIS;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_PRIME = wsfh_pkg::CFG_HASH_PRIME;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODULUS = wsfh_pkg::CFG_HASH_MODULUS;

	typedef struct packed {
		logic [BYTE_W-1:0] text;
		logic wl;
		logic dl;
	} text_item_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic fin;
	} shingle_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [BYTE_W-1:0] text_byte = '0;
	logic word_last = 1'b0;
	logic doc_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [HASH_W-1:0] shingle_hash;
	logic final_shingle;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [HASH_W-1:0] cfg_data = '0;

	text_item_t pending_bytes[$];
	shingle_t expected_shingles[$];
	text_item_t cur_item;
	shingle_t want;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int bytes_sent = 0;
	int hashes_seen = 0;
	int docs_queued = 0;
	int settings_used = 0;

	logic [HASH_W-1:0] offset_r;
	logic [HASH_W-1:0] prime_r;
	logic [HASH_W-1:0] modulus_r;
	logic [HASH_W-1:0] window_acc [WINDOW_WORDS];
	int words_done;
	int oldest_win;

	word_shingle_fnv_hasher_unit dut (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic restart_windows();
		for (int k = 0; k < WINDOW_WORDS; k++) window_acc[k] = offset_r;
		words_done = 0;
		oldest_win = 0;
	endtask

	function automatic logic [HASH_W-1:0] reduce_hash(logic [HASH_W-1:0] h);
		return (modulus_r == '0) ? h : h % modulus_r;
	endfunction

	task automatic hash_byte(text_item_t it);
		logic [HASH_W-1:0] ext;
		logic all_on;
		shingle_t s;
		ext = {{(HASH_W-BYTE_W){it.text[BYTE_W-1]}}, it.text};
		all_on = (words_done + 1 >= WINDOW_WORDS);
		for (int k = 0; k < WINDOW_WORDS; k++) begin
			if (all_on || k <= words_done) window_acc[k] = (window_acc[k] * prime_r) ^ ext;
		end
		if (it.wl || it.dl) begin
			if (words_done + 1 >= WINDOW_WORDS || it.dl) begin
				s.hash = reduce_hash(window_acc[oldest_win]);
				s.fin = it.dl;
				expected_shingles.insert(expected_shingles.size(), s);
				if (it.dl) begin
					restart_windows();
				end else begin
					window_acc[oldest_win] = offset_r;
					oldest_win = (oldest_win + 1) % WINDOW_WORDS;
					words_done = WINDOW_WORDS;
				end
			end else begin
				words_done++;
			end
		end
	endtask

	task automatic report_mismatch(string what, logic [HASH_W-1:0] got,
			logic [HASH_W-1:0] ref_v);
		$display("mismatch %s: got %h expected %h at %0t", what, got, ref_v, $time);
		errors++;
	endtask

	task automatic write_regs(logic [HASH_W-1:0] ob, logic [HASH_W-1:0] pr,
			logic [HASH_W-1:0] md);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [HASH_W-1:0] vals [3];
		idx = '{CFG_OFFSET_BASIS, CFG_HASH_PRIME, CFG_HASH_MODULUS};
		vals = '{ob, pr, md};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				CFG_OFFSET_BASIS: offset_r = vals[i];
				CFG_HASH_PRIME: prime_r = vals[i];
				CFG_HASH_MODULUS: modulus_r = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic push_item(logic [BYTE_W-1:0] t, logic wl, logic dl);
		text_item_t it;
		it.text = t;
		it.wl = wl;
		it.dl = dl;
		pending_bytes.insert(pending_bytes.size(), it);
	endtask

	task automatic settle();
		while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
		while (expected_shingles.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [HASH_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h80;
			3: return 8'h7f;
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	task automatic queue_document();
		int nwords;
		int wlen;
		text_item_t it;
		nwords = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(9, 1);
		for (int w = 0; w < nwords; w++) begin
			wlen = ($urandom_range(4) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
			for (int b = 0; b < wlen; b++) begin
				it.text = pick_byte();
				it.wl = (b == wlen - 1);
				it.dl = 1'b0;
				if (w == nwords - 1 && b == wlen - 1) begin
					it.dl = 1'b1;
					it.wl = 1'($urandom_range(1));
				end
				// Occasional broken framing: marks flipped at random.
				if ($urandom_range(19) == 0) begin
					it.wl = 1'($urandom_range(1));
					it.dl = 1'($urandom_range(1));
				end
				pending_bytes.insert(pending_bytes.size(), it);
			end
		end
		docs_queued++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				hash_byte(cur_item);
				bytes_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_item = pending_bytes.pop_front();
					text_byte <= cur_item.text;
					word_last <= cur_item.wl;
					doc_last <= cur_item.dl;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_shingles.size() == 0) begin
				report_mismatch("unexpected transaction", shingle_hash, '0);
			end else begin
				want = expected_shingles.pop_front();
				if (shingle_hash !== want.hash) report_mismatch("shingle_hash", shingle_hash, want.hash);
				if (final_shingle !== want.fin)
					report_mismatch("final_shingle", HASH_W'(final_shingle), HASH_W'(want.fin));
				hashes_seen++;
			end
		end
	end

	initial begin
		offset_r = OFFSET_RESET;
		prime_r = PRIME_RESET;
		modulus_r = MODULUS_RESET;
		restart_windows();
		send_idle_pct = 12;
		recv_idle_pct = 61;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset register values.
		push_item(8'h00, 1'b0, 1'b1);
		push_item(8'hff, 1'b1, 1'b1);
		push_item(8'h80, 1'b1, 1'b0);
		push_item(8'h7f, 1'b1, 1'b0);
		push_item(8'h01, 1'b0, 1'b0);
		push_item(8'hfe, 1'b1, 1'b0);
		push_item(8'hc3, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b0);
		push_item(8'h55, 1'b1, 1'b0);
		push_item(8'haa, 1'b0, 1'b1);
		push_item(8'h11, 1'b1, 1'b0);
		push_item(8'hff, 1'b0, 1'b0);
		push_item(8'h80, 1'b1, 1'b0);
		push_item(8'h22, 1'b1, 1'b0);
		settle();
		// The registers change in the middle of a document here.
		write_regs(64'h0123456789abcdef, 64'd3, '0);
		push_item(8'h33, 1'b1, 1'b0);
		push_item(8'h44, 1'b1, 1'b0);
		push_item(8'h99, 1'b1, 1'b0);
		push_item(8'hee, 1'b1, 1'b1);
		push_item(8'h01, 1'b1, 1'b0);
		push_item(8'h01, 1'b1, 1'b0);
		push_item(8'h01, 1'b1, 1'b0);
		push_item(8'h02, 1'b1, 1'b1);
		settle();

		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				send_idle_pct = 12;
				recv_idle_pct = 61;
			end else if (p < 4) begin
				send_idle_pct = 61;
				recv_idle_pct = 12;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
				0: write_regs(OFFSET_RESET, PRIME_RESET, MODULUS_RESET);
				1: write_regs('1, '1, '1);
				2: write_regs('0, '0, '0);
				3: write_regs(rand64(), rand64(), 64'd1);
				4: write_regs(rand64(), rand64() | 64'd1, 64'($urandom_range(1000, 2)));
				default: write_regs(rand64(), rand64(), rand64());
			endcase
			while (pending_bytes.size() < 320) queue_document();
			settle();
		end

		repeat (100) @(posedge clk);
		$display("covered %0d bytes in %0d random documents plus directed cases, %0d settings",
			bytes_sent, docs_queued, settings_used);
		$display("checked %0d shingle hashes, %0d mismatches", hashes_seen, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(8 * 3000000);
		$display("timeout with %0d shingle hashes outstanding", expected_shingles.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
